>>> hdl/quantized_int8_elementwise_add_macros.svh
// assertion helpers shared by the rtl
`ifndef QUANTIZED_INT8_ELEMENTWISE_ADD_MACROS_SVH
`define QUANTIZED_INT8_ELEMENTWISE_ADD_MACROS_SVH

// antecedent implies consequent in the same cycle
`define QI8ADD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define QI8ADD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/qi8add_pkg.sv
package qi8add_pkg;

  localparam int NSTG = 9;

  typedef enum logic [2:0] {
    CFG_FIRST_OFFSET  = 3'd0,
    CFG_SECOND_OFFSET = 3'd1,
    CFG_FIRST_SCALE   = 3'd2,
    CFG_SECOND_SCALE  = 3'd3,
    CFG_RESULT_SCALE  = 3'd4,
    CFG_RESULT_OFFSET = 3'd5,
    CFG_CLAMP_LOW     = 3'd6,
    CFG_CLAMP_HIGH    = 3'd7
  } cfg_idx_t;

  localparam logic [37:0] SCALE_RESET = 38'd1073741824;
  localparam logic [31:0] INT32_MAX = 32'h7fff_ffff;
  localparam logic [31:0] INT32_MIN = 32'h8000_0000;
  localparam logic [63:0] HALF_NUDGE = 64'h0000_0000_4000_0000;

  // left part of the signed shift field
  function automatic logic [4:0] shl_amt(logic [5:0] sh);
    return sh[5] ? 5'd0 : sh[4:0];
  endfunction

  // right part of the signed shift field, 0 to 32
  function automatic logic [5:0] shr_amt(logic [5:0] sh);
    return sh[5] ? 6'(-sh) : 6'd0;
  endfunction

  // high word of the doubled product, rounded half up (toward +inf)
  function automatic logic [31:0] dbl_high(logic [63:0] prod, logic sat);
    logic [63:0] t;
    t = prod + HALF_NUDGE;
    return sat ? INT32_MAX : t[62:31];
  endfunction

  // arithmetic right shift, rounding half away from zero
  function automatic logic [31:0] round_rshift(logic [31:0] x, logic [5:0] e);
    logic [32:0] mask;
    logic [32:0] rem;
    logic [32:0] thr;
    logic signed [31:0] q;
    mask = (33'd1 << e) - 33'd1;
    q = $signed(x) >>> e;
    rem = {1'b0, x} & mask;
    thr = (mask >> 1) + {32'd0, x[31]};
    return (rem > thr) ? 32'(q + 32'sd1) : 32'(q);
  endfunction

endpackage

>>> hdl/quantized_int8_elementwise_add.sv
// Quantized int8 element-wise add. Each item carries one pair of int8 values; each value
// gets its offset, a fixed left shift of PRE_SHIFT and its own fixed-point rescale, the
// two are summed, rescaled again, offset and clamped to the activation bounds. The block
// is a nine-stage pipeline with one 32x32 multiplier per operand in the first rescale
// step and one for the sum in the second. It takes one item every cycle while the output
// is not stalled; stalls on the output back up stage by stage with no bubbles added.
// Configuration writes are taken at any time (cfg_ready is always high) and must only be
// made while no item is in flight.
module quantized_int8_elementwise_add #(
  parameter int PRE_SHIFT = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [7:0] in_first_value,
  input  logic signed [7:0] in_second_value,
  input  logic              in_final_element,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [7:0] out_sum_value,
  output logic              out_final_result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [37:0]       cfg_data
);
  import qi8add_pkg::*;

  // configuration
  logic signed [8:0] first_offset_r;
  logic signed [8:0] second_offset_r;
  logic [37:0]       first_scale_r;
  logic [37:0]       second_scale_r;
  logic [37:0]       result_scale_r;
  logic signed [7:0] result_offset_r;
  logic signed [7:0] clamp_low_r;
  logic signed [7:0] clamp_high_r;

  // pipeline control
  logic [NSTG-1:0] valid_r;
  logic [NSTG-1:0] valid_nxt;
  logic [NSTG-1:0] last_r;
  logic [NSTG-1:0] last_nxt;
  logic [NSTG-1:0] rdy;

  // stage data
  logic [31:0] va_r, vb_r, va_nxt, vb_nxt;
  logic [63:0] prod_a_r, prod_b_r;
  logic signed [63:0] prod_a_nxt, prod_b_nxt;
  logic sat_a_r, sat_b_r, sat_a_nxt, sat_b_nxt;
  logic [31:0] d_a_r, d_b_r, d_a_nxt, d_b_nxt;
  logic [31:0] q_a_r, q_b_r, q_a_nxt, q_b_nxt;
  logic [31:0] vs_r, vs_nxt;
  logic [63:0] prod_s_r;
  logic signed [63:0] prod_s_nxt;
  logic sat_s_r, sat_s_nxt;
  logic [31:0] d_s_r, d_s_nxt;
  logic [31:0] q_s_r, q_s_nxt;
  logic signed [7:0] sum_r, sum_nxt;

  logic signed [9:0] off_a, off_b;
  logic [31:0] ext_a, ext_b, sum32;
  logic signed [32:0] fin;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_offset_r  <= '0;
      second_offset_r <= '0;
      first_scale_r   <= SCALE_RESET;
      second_scale_r  <= SCALE_RESET;
      result_scale_r  <= SCALE_RESET;
      result_offset_r <= '0;
      clamp_low_r     <= -8'sd128;
      clamp_high_r    <= 8'sd127;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FIRST_OFFSET:  first_offset_r  <= cfg_data[8:0];
        CFG_SECOND_OFFSET: second_offset_r <= cfg_data[8:0];
        CFG_FIRST_SCALE:   first_scale_r   <= cfg_data;
        CFG_SECOND_SCALE:  second_scale_r  <= cfg_data;
        CFG_RESULT_SCALE:  result_scale_r  <= cfg_data;
        CFG_RESULT_OFFSET: result_offset_r <= cfg_data[7:0];
        CFG_CLAMP_LOW:     clamp_low_r     <= cfg_data[7:0];
        CFG_CLAMP_HIGH:    clamp_high_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // backpressure: a stage may load when empty or when the next one loads
  always_comb begin
    rdy[NSTG-1] = out_ready || !valid_r[NSTG-1];
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !valid_r[i] || rdy[i+1];
    end
    valid_nxt = {valid_r[NSTG-2:0], in_valid};
    last_nxt  = {last_r[NSTG-2:0], in_final_element};
  end

  assign in_ready         = rdy[0];
  assign out_valid        = valid_r[NSTG-1];
  assign out_sum_value    = sum_r;
  assign out_final_result = last_r[NSTG-1];

  always_comb begin
    // stage 0: offset, pre-shift and requant left shift
    off_a  = 10'(in_first_value) + 10'(first_offset_r);
    off_b  = 10'(in_second_value) + 10'(second_offset_r);
    ext_a  = 32'(off_a);
    ext_b  = 32'(off_b);
    va_nxt = (ext_a << PRE_SHIFT) << shl_amt(first_scale_r[37:32]);
    vb_nxt = (ext_b << PRE_SHIFT) << shl_amt(second_scale_r[37:32]);
    // stage 1: products
    prod_a_nxt = 64'($signed(va_r)) * 64'($signed(first_scale_r[31:0]));
    prod_b_nxt = 64'($signed(vb_r)) * 64'($signed(second_scale_r[31:0]));
    sat_a_nxt  = (va_r == INT32_MIN) && (first_scale_r[31:0] == INT32_MIN);
    sat_b_nxt  = (vb_r == INT32_MIN) && (second_scale_r[31:0] == INT32_MIN);
    // stage 2: doubling high word
    d_a_nxt = dbl_high(prod_a_r, sat_a_r);
    d_b_nxt = dbl_high(prod_b_r, sat_b_r);
    // stage 3: rounding right shift
    q_a_nxt = round_rshift(d_a_r, shr_amt(first_scale_r[37:32]));
    q_b_nxt = round_rshift(d_b_r, shr_amt(second_scale_r[37:32]));
    // stage 4: sum and result left shift
    sum32  = q_a_r + q_b_r;
    vs_nxt = sum32 << shl_amt(result_scale_r[37:32]);
    // stage 5: result product
    prod_s_nxt = 64'($signed(vs_r)) * 64'($signed(result_scale_r[31:0]));
    sat_s_nxt  = (vs_r == INT32_MIN) && (result_scale_r[31:0] == INT32_MIN);
    // stage 6 and 7
    d_s_nxt = dbl_high(prod_s_r, sat_s_r);
    q_s_nxt = round_rshift(d_s_r, shr_amt(result_scale_r[37:32]));
    // stage 8: output offset and clamp
    fin = 33'($signed(q_s_r)) + 33'(result_offset_r);
    if (fin < 33'(clamp_low_r)) begin
      fin = 33'(clamp_low_r);
    end
    if (fin > 33'(clamp_high_r)) begin
      fin = 33'(clamp_high_r);
    end
    sum_nxt = fin[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (rdy[i]) begin
          valid_r[i] <= valid_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NSTG; i++) begin
      if (rdy[i]) begin
        last_r[i] <= last_nxt[i];
      end
    end
    if (rdy[0]) begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
    end
    if (rdy[1]) begin
      prod_a_r <= prod_a_nxt;
      prod_b_r <= prod_b_nxt;
      sat_a_r  <= sat_a_nxt;
      sat_b_r  <= sat_b_nxt;
    end
    if (rdy[2]) begin
      d_a_r <= d_a_nxt;
      d_b_r <= d_b_nxt;
    end
    if (rdy[3]) begin
      q_a_r <= q_a_nxt;
      q_b_r <= q_b_nxt;
    end
    if (rdy[4]) begin
      vs_r <= vs_nxt;
    end
    if (rdy[5]) begin
      prod_s_r <= prod_s_nxt;
      sat_s_r  <= sat_s_nxt;
    end
    if (rdy[6]) begin
      d_s_r <= d_s_nxt;
    end
    if (rdy[7]) begin
      q_s_r <= q_s_nxt;
    end
    if (rdy[8]) begin
      sum_r <= sum_nxt;
    end
  end

`include "quantized_int8_elementwise_add_macros.svh"

  `QI8ADD_ASSERT_NEXT(a_accept_fills, in_valid && in_ready, valid_r[0], "accepted item lost")
  `QI8ADD_ASSERT_SAME(a_full_blocks, (&valid_r) && !out_ready, !in_ready, "full pipe took item")
  `QI8ADD_ASSERT_NEXT(a_sat_high, valid_r[1] && sat_a_r && rdy[2], d_a_r == INT32_MAX, "sat lost")

endmodule
